// ----- rtl/core/gaussian_5x5_rgb_filter_defines.svh -----
// Assertion macros shared by the filter RTL.
// Clock and reset are taken from the scope of the module that uses them.
`ifndef GAUSSIAN_5X5_RGB_FILTER_DEFINES_SVH
`define GAUSSIAN_5X5_RGB_FILTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("filter assertion failed");
`define GF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("filter assertion failed");
`else
`define GF_ASSERT_IMP(lbl, ante, cons)
`define GF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/gf_pkg.sv -----
`timescale 1ns / 1ps
package gf_pkg;
	localparam int PIX_W      = 16;
	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = 10;
	localparam int FW_W       = 11;
	localparam int FH_W       = 12;
	localparam int ROW_W      = 12;
	localparam int RPOS_W     = 13;
	localparam int NUM_BANKS  = 4;
	localparam int BANK_W     = 2;
	localparam int KDIM       = 5;
	localparam int WT_W       = 6;
	localparam int COLSUM_W   = 23;
	localparam int ACC_W      = 25;
	localparam int PROD_W     = 2 * ACC_W;
	localparam int RECIP_SHIFT = 33;
	localparam int KNORM      = 273;
	localparam int ROUND_ADD  = 136;
	// ceil(2^33 / 273): exact quotient for every sum below 2^25
	localparam logic [ACC_W-1:0] RECIP =
		ACC_W'((64'd1 << RECIP_SHIFT) / 64'(KNORM) + 64'd1);
	localparam int QDEPTH     = 8;
	localparam int QPTR_W     = 3;
	localparam int QCNT_W     = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd231;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd338;

	typedef struct packed {
		logic [PIX_W-1:0] a;
		logic [PIX_W-1:0] b;
		logic [PIX_W-1:0] c;
	} pix_t;

	typedef pix_t [KDIM-1:0] col_t;
	typedef pix_t [NUM_BANKS-1:0] bank_rd_t;
	typedef logic [KDIM-1:0][WT_W-1:0] wvec_t;

	typedef struct packed {
		logic [COLSUM_W-1:0] a;
		logic [COLSUM_W-1:0] b;
		logic [COLSUM_W-1:0] c;
	} csum_t;

	typedef struct packed {
		logic emit;
		logic border;
		logic multi;
		logic done;
	} ctrl_t;

	typedef struct packed {
		pix_t main;
		pix_t next;
		pix_t last;
		logic multi;
		logic done;
	} grp_t;

	function automatic wvec_t kern_col(input int j);
		wvec_t w;
		case (j)
			1, 3: w = {6'd4, 6'd16, 6'd26, 6'd16, 6'd4};
			2: w = {6'd7, 6'd26, 6'd41, 6'd26, 6'd7};
			default: w = {6'd1, 6'd4, 6'd7, 6'd4, 6'd1};
		endcase
		return w;
	endfunction
endpackage

// ----- rtl/core/gf_in_if.sv -----
`timescale 1ns / 1ps
interface gf_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] chan_a;
	logic [15:0] chan_b;
	logic [15:0] chan_c;
	modport source (output valid, kind, chan_a, chan_b, chan_c, input ready);
	modport sink (input valid, kind, chan_a, chan_b, chan_c, output ready);
endinterface

// ----- rtl/core/gf_out_if.sv -----
`timescale 1ns / 1ps
interface gf_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_a;
	logic [15:0] out_b;
	logic [15:0] out_c;
	logic        last_in_run;
	logic        frame_done;
	modport source (output valid, out_a, out_b, out_c, last_in_run, frame_done,
		input ready);
	modport sink (input valid, out_a, out_b, out_c, last_in_run, frame_done,
		output ready);
endinterface

// ----- rtl/core/gaussian_5x5_rgb_filter.sv -----
`timescale 1ns / 1ps
`include "gaussian_5x5_rgb_filter_defines.svh"
// 5x5 Gaussian blur (weights 1-4-7-4-1 / 4-16-26-16-4 / 7-26-41-26-7, sum 273,
// rounded half up) over a three-channel 16-bit frame sent in raster order, one
// pixel per transfer. The block takes one pixel every clock while the result
// queue has room and sends one result every clock while the consumer is ready;
// a row of W pixels yields W results, lagging two rows and two columns, and the
// last column of a row yields three. Pixels within two of any edge pass
// unchanged. After the last pixel, send 2*W flush items (kind = 1) to drain
// the bottom two rows; a flush while pixels are expected, or a pixel while
// draining, is taken and dropped. Each of four row banks has a single write
// port, and a result queue of eight groups applies backpressure once it is
// fully reserved. Write frame_width and frame_height only while idle.
module gaussian_5x5_rgb_filter import gf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	gf_in_if.sink                 pix_in,
	gf_out_if.source              pix_out
);
	logic [FW_W-1:0]   width_q;
	logic [FH_W-1:0]   height_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  in_col_q;
	logic [1:0]        drain_q;
	logic [QCNT_W-1:0] credit_q;

	logic [FW_W-1:0]   w_eff;
	logic [FH_W-1:0]   h_eff;
	logic [RPOS_W-1:0] r, orow;
	logic [COL_W-1:0]  c, ocol;
	logic              accept, take, take_emit, lastcol;
	ctrl_t             ctrl;
	pix_t              cur;
	logic              q_pop;

	// clamp the frame geometry
	always_comb begin
		if (width_q < FW_W'(KDIM)) begin
			w_eff = FW_W'(KDIM);
		end else if (width_q > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q < FH_W'(KDIM)) ? FH_W'(KDIM) : height_q;
	end

	assign accept = pix_in.valid && pix_in.ready;
	// a pixel is used while taking pixels, a flush only while draining
	assign take   = accept && ((drain_q == 2'd0) == (pix_in.kind == 1'b0));
	assign cur    = '{a: pix_in.chan_a, b: pix_in.chan_b, c: pix_in.chan_c};

	always_comb begin
		r = (drain_q == 2'd0) ? RPOS_W'(in_row_q)
			: RPOS_W'(h_eff) - RPOS_W'(1) + RPOS_W'(drain_q);
		c = (FW_W'(in_col_q) < w_eff) ? in_col_q : COL_W'(w_eff - FW_W'(1));
		orow = r - RPOS_W'(2);
		ocol = c - COL_W'(2);
		lastcol = FW_W'(c) >= w_eff - FW_W'(1);
		ctrl.emit   = r >= RPOS_W'(2) && c >= COL_W'(2);
		ctrl.border = orow < RPOS_W'(2) || orow >= RPOS_W'(h_eff) - RPOS_W'(2)
			|| ocol < COL_W'(2) || FW_W'(ocol) >= w_eff - FW_W'(2);
		ctrl.multi  = lastcol;
		ctrl.done   = orow == RPOS_W'(h_eff) - RPOS_W'(1);
	end

	assign take_emit = take && ctrl.emit;

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
			in_row_q <= '0;
			in_col_q <= '0;
			drain_q  <= 2'd0;
		end else begin
			if (cfg_we && cfg_index == REG_FRAME_WIDTH) begin
				width_q <= cfg_data[FW_W-1:0];
			end
			if (cfg_we && cfg_index == REG_FRAME_HEIGHT) begin
				height_q <= cfg_data[FH_W-1:0];
			end
			if (take) begin
				if (lastcol) begin
					in_col_q <= '0;
					if (drain_q != 2'd0) begin
						drain_q <= (drain_q >= 2'd2) ? 2'd0 : drain_q + 2'd1;
					end else if (in_row_q >= h_eff - FH_W'(1)) begin
						in_row_q <= '0;
						drain_q  <= 2'd1;
					end else begin
						in_row_q <= in_row_q + ROW_W'(1);
					end
				end else begin
					in_col_q <= c + COL_W'(1);
				end
			end
		end
	end

	// reserve one queue group per emitting item, release on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + QCNT_W'(take_emit) - QCNT_W'(q_pop);
		end
	end

	assign pix_in.ready = credit_q != QCNT_W'(QDEPTH);

	// line store: write current pixel at its slot, read four older rows
	bank_rd_t rd_data;

	gf_line_store u_lines (
		.clk   (clk),
		.en    (take),
		.wbank (r[BANK_W-1:0]),
		.addr  (c),
		.wdata (cur),
		.rdata (rd_data)
	);

	// stage 1: build the new column while the bank reads arrive
	logic              v_s1;
	pix_t              cur_s1;
	logic [BANK_W-1:0] slot_s1;
	ctrl_t             ctrl_s1;
	col_t              newcol;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		cur_s1  <= cur;
		slot_s1 <= r[BANK_W-1:0];
		ctrl_s1 <= ctrl;
	end

	always_comb begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			newcol[k] = rd_data[BANK_W'(slot_s1 + BANK_W'(k))];
		end
		newcol[KDIM-1] = cur_s1;
	end

	// window: five column cells, each handing its column to the older neighbor
	col_t  cell_col [KDIM];
	col_t  cell_in  [KDIM];
	csum_t colsum_s3 [KDIM];

	for (genvar j = 0; j < KDIM; j++) begin : g_cell
		if (j == KDIM - 1) begin : g_head
			assign cell_in[j] = newcol;
		end else begin : g_body
			assign cell_in[j] = cell_col[j+1];
		end
		gf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (v_s1),
			.din    (cell_in[j]),
			.wts    (kern_col(j)),
			.col_q  (cell_col[j]),
			.sum_s3 (colsum_s3[j])
		);
	end

	// stage 2: window holds this item; cells form column sums
	logic  v_s2, v_s3, v_s4, v_s5;
	ctrl_t ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	pix_t  p22_s3, p32_s3, p42_s3;
	pix_t  p22_s4, p32_s4, p42_s4;
	pix_t  p22_s5, p32_s5, p42_s5;
	logic [ACC_W-1:0]  acc_a, acc_b, acc_c;
	logic [ACC_W-1:0]  acc_a_s4, acc_b_s4, acc_c_s4;
	logic [PROD_W-1:0] prod_a_s5, prod_b_s5, prod_c_s5;
	grp_t grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && ctrl_s1.emit;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		acc_a = ACC_W'(ROUND_ADD);
		acc_b = ACC_W'(ROUND_ADD);
		acc_c = ACC_W'(ROUND_ADD);
		for (int j = 0; j < KDIM; j++) begin
			acc_a = acc_a + ACC_W'(colsum_s3[j].a);
			acc_b = acc_b + ACC_W'(colsum_s3[j].b);
			acc_c = acc_c + ACC_W'(colsum_s3[j].c);
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s2   <= ctrl_s1;
		ctrl_s3   <= ctrl_s2;
		p22_s3    <= cell_col[2][2];
		p32_s3    <= cell_col[3][2];
		p42_s3    <= cell_col[4][2];
		ctrl_s4   <= ctrl_s3;
		p22_s4    <= p22_s3;
		p32_s4    <= p32_s3;
		p42_s4    <= p42_s3;
		acc_a_s4  <= acc_a;
		acc_b_s4  <= acc_b;
		acc_c_s4  <= acc_c;
		ctrl_s5   <= ctrl_s4;
		p22_s5    <= p22_s4;
		p32_s5    <= p32_s4;
		p42_s5    <= p42_s4;
		// divide by 273 through the reciprocal
		prod_a_s5 <= PROD_W'(acc_a_s4) * PROD_W'(RECIP);
		prod_b_s5 <= PROD_W'(acc_b_s4) * PROD_W'(RECIP);
		prod_c_s5 <= PROD_W'(acc_c_s4) * PROD_W'(RECIP);
	end

	// stage 5: pick blurred or border pixel and hand the group to the queue
	always_comb begin
		if (ctrl_s5.border) begin
			grp.main = p22_s5;
		end else begin
			grp.main.a = prod_a_s5[RECIP_SHIFT +: PIX_W];
			grp.main.b = prod_b_s5[RECIP_SHIFT +: PIX_W];
			grp.main.c = prod_c_s5[RECIP_SHIFT +: PIX_W];
		end
		grp.next  = p32_s5;
		grp.last  = p42_s5;
		grp.multi = ctrl_s5.multi;
		grp.done  = ctrl_s5.done;
	end

	gf_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s5),
		.push_data (grp),
		.out_ch    (pix_out),
		.pop       (q_pop)
	);

	`GF_ASSERT_IMP(a_credit_bound, 1'b1, credit_q <= QCNT_W'(QDEPTH))
	`GF_ASSERT_NXT(a_drain_exit, take && lastcol && drain_q == 2'd2, drain_q == 2'd0 && in_row_q == '0)
	`GF_ASSERT_IMP(a_done_is_last, pix_out.valid && pix_out.frame_done, pix_out.last_in_run)
	`GF_ASSERT_NXT(a_credit_take, take_emit && !q_pop, credit_q == $past(credit_q) + QCNT_W'(1))
endmodule

// ----- rtl/core/gf_line_store.sv -----
`timescale 1ns / 1ps
module gf_line_store import gf_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [BANK_W-1:0] wbank,
	input  logic [COL_W-1:0]  addr,
	input  pix_t              wdata,
	output bank_rd_t          rdata
);
	// one bank per row slot, all read at the same column
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		pix_t mem [MAX_WIDTH];
		pix_t rd_q;
		always_ff @(posedge clk) begin
			if (en && wbank == BANK_W'(b)) begin
				mem[addr] <= wdata;
			end
			if (en) begin
				rd_q <= mem[addr];
			end
		end
		assign rdata[b] = rd_q;
	end
endmodule

// ----- rtl/core/gf_cell.sv -----
`timescale 1ns / 1ps
module gf_cell import gf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  col_t  din,
	input  wvec_t wts,
	output col_t  col_q,
	output csum_t sum_s3
);
	csum_t sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= din;
		end
	end

	// weighted sum of this column, one kernel column
	always_comb begin
		sum = '0;
		for (int p = 0; p < KDIM; p++) begin
			sum.a = sum.a + COLSUM_W'(wts[p]) * COLSUM_W'(col_q[p].a);
			sum.b = sum.b + COLSUM_W'(wts[p]) * COLSUM_W'(col_q[p].b);
			sum.c = sum.c + COLSUM_W'(wts[p]) * COLSUM_W'(col_q[p].c);
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= sum;
	end
endmodule

// ----- rtl/core/gf_out_queue.sv -----
`timescale 1ns / 1ps
module gf_out_queue import gf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_t push_data,
	gf_out_if.source out_ch,
	output logic pop
);
	localparam logic [1:0] RES_FIRST = 2'd0;
	localparam logic [1:0] RES_NEXT  = 2'd1;
	localparam logic [1:0] RES_LAST  = 2'd2;

	grp_t mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [1:0]        sub_q;
	grp_t              head;
	logic              xfer;

	assign head         = mem[rd_ptr_q];
	assign out_ch.valid = count_q != '0;
	assign xfer         = out_ch.valid && out_ch.ready;
	assign pop          = xfer && (!head.multi || sub_q == RES_LAST);

	always_comb begin
		unique case (sub_q)
			RES_NEXT: begin
				{out_ch.out_a, out_ch.out_b, out_ch.out_c} = head.next;
				out_ch.last_in_run = 1'b0;
				out_ch.frame_done  = 1'b0;
			end
			RES_LAST: begin
				{out_ch.out_a, out_ch.out_b, out_ch.out_c} = head.last;
				out_ch.last_in_run = 1'b1;
				out_ch.frame_done  = head.done;
			end
			default: begin
				{out_ch.out_a, out_ch.out_b, out_ch.out_c} = head.main;
				out_ch.last_in_run = !head.multi;
				out_ch.frame_done  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= RES_FIRST;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
			if (pop) begin
				sub_q <= RES_FIRST;
			end else if (xfer) begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end
endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import gf_pkg::*;

	typedef struct {
		logic  kind;
		pix_t  px;
	} stim_t;

	typedef struct {
		pix_t  px;
		logic  last_in_run;
		logic  frame_done;
	} blur_out_t;

	localparam int KERNEL [5][5] = '{
		'{1, 4, 7, 4, 1},
		'{4, 16, 26, 16, 4},
		'{7, 26, 41, 26, 7},
		'{4, 16, 26, 16, 4},
		'{1, 4, 7, 4, 1}
	};
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gf_in_if  pix_in ();
	gf_out_if pix_out ();

	gaussian_5x5_rgb_filter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_in   (pix_in.sink),
		.pix_out  (pix_out.source)
	);

	// Pending input items, filled by the stimulus process, drained by the driver.
	stim_t     pend_q[$];
	// Blurred or passed-through pixels the filter still owes us, oldest first.
	blur_out_t blur_q[$];
	int        n_errors;
	logic      took;

	// Shadow copy of the filter state, updated on every accepted transfer that is not dropped.
	pix_t        line_mem [4*MAX_WIDTH];
	pix_t        win [5][5];
	int unsigned sh_row, sh_col, sh_drain;
	int unsigned sh_width, sh_height;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(input string what);
		$display("ERROR @%0t: %s", $time, what);
		n_errors++;
	endtask

	function automatic logic [PIX_W-1:0] chan(input pix_t p, input int n);
		case (n)
			0: return p.a;
			1: return p.b;
			default: return p.c;
		endcase
	endfunction

	function automatic pix_t blur_window();
		pix_t res;
		longint acc;
		logic [PIX_W-1:0] q [3];
		for (int n = 0; n < 3; n++) begin
			acc = 0;
			for (int p = 0; p < 5; p++)
				for (int k = 0; k < 5; k++)
					acc += KERNEL[p][k] * longint'(chan(win[k][p], n));
			q[n] = PIX_W'((acc + 136) / 273);
		end
		res.a = q[0];
		res.b = q[1];
		res.c = q[2];
		return res;
	endfunction

	function automatic void push_result(input pix_t p, input logic last, input logic done);
		blur_out_t r;
		r.px = p;
		r.last_in_run = last;
		r.frame_done = done;
		blur_q.push_back(r);
	endfunction

	// Advance the shadow filter by one accepted item and queue what it emits.
	function automatic void predict_blur(input logic kind, input pix_t cur);
		int unsigned w, h, r, c, orow, ocol;
		pix_t column [5];
		pix_t v;
		logic lastcol;
		w = (sh_width < 5) ? 5 : ((sh_width > MAX_WIDTH) ? MAX_WIDTH : sh_width);
		h = (sh_height < 5) ? 5 : sh_height;
		// drop mismatched kinds: no results, no state change
		if ((sh_drain == 0) != (kind == KIND_PIXEL))
			return;
		r = (sh_drain == 0) ? sh_row : h - 1 + sh_drain;
		c = (sh_col < w) ? sh_col : w - 1;
		for (int k = 0; k < 4; k++)
			column[k] = line_mem[((r + k) % 4) * MAX_WIDTH + c];
		column[4] = cur;
		line_mem[(r % 4) * MAX_WIDTH + c] = cur;
		for (int k = 0; k < 4; k++)
			win[k] = win[k+1];
		win[4] = column;
		if (r >= 2 && c >= 2) begin
			ocol = c - 2;
			orow = r - 2;
			lastcol = (c >= w - 1);
			if (orow < 2 || orow >= h - 2 || ocol < 2 || ocol >= w - 2)
				v = win[2][2];
			else
				v = blur_window();
			push_result(v, !lastcol, 1'b0);
			if (lastcol) begin
				push_result(win[3][2], 1'b0, 1'b0);
				push_result(win[4][2], 1'b1, orow == h - 1);
			end
		end
		if (c >= w - 1) begin
			sh_col = 0;
			if (sh_drain != 0)
				sh_drain = (sh_drain >= 2) ? 0 : sh_drain + 1;
			else if (sh_row >= h - 1) begin
				sh_row = 0;
				sh_drain = 1;
			end else
				sh_row++;
		end else
			sh_col = c + 1;
	endfunction

	// Random sample, biased toward the extremes now and then.
	function automatic pix_t rand_pix();
		pix_t p;
		logic [PIX_W-1:0] s [3];
		for (int n = 0; n < 3; n++)
			case ($urandom_range(0, 7))
				0: s[n] = '0;
				1: s[n] = '1;
				default: s[n] = PIX_W'($urandom);
			endcase
		p.a = s[0];
		p.b = s[1];
		p.c = s[2];
		return p;
	endfunction

	function automatic void queue_item(input logic kind, input pix_t p);
		stim_t s;
		s.kind = kind;
		s.px = p;
		pend_q.push_back(s);
	endfunction

	// Queue one whole frame plus its flush rows; noise adds ignored items.
	function automatic void queue_frame(input int unsigned w, input int unsigned h,
			input int unsigned noise);
		for (int i = 0; i < w * h; i++) begin
			if (noise != 0 && $urandom_range(0, noise) == 0)
				queue_item(KIND_FLUSH, rand_pix());
			queue_item(KIND_PIXEL, rand_pix());
		end
		for (int i = 0; i < 2 * w; i++) begin
			if (noise != 0 && $urandom_range(0, noise) == 0)
				queue_item(KIND_PIXEL, rand_pix());
			queue_item(KIND_FLUSH, rand_pix());
		end
	endfunction

	// Write one register at a falling edge and mirror it in the shadow copy.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			sh_width = val & 12'h7FF;
		else
			sh_height = val & 12'hFFF;
	endtask

	// Wait until every item is sent and every result is back, then let the
	// pipeline settle in case a dropped item is still in flight.
	task automatic wait_idle();
		while (pend_q.size() != 0 || pix_in.valid || blur_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic run_frame(input int unsigned wreg, input int unsigned hreg,
			input int unsigned noise);
		int unsigned w, h;
		write_reg(REG_FRAME_WIDTH, wreg);
		write_reg(REG_FRAME_HEIGHT, hreg);
		w = sh_width < 5 ? 5 : (sh_width > MAX_WIDTH ? MAX_WIDTH : sh_width);
		h = sh_height < 5 ? 5 : sh_height;
		queue_frame(w, h, noise);
		wait_idle();
	endtask

	// Driver: hold an item until it transfers, send in bursts with gaps between.
	int unsigned burst_left = 8;
	int unsigned gap_left = 0;
	always @(negedge clk) begin
		logic nv;
		stim_t s;
		nv = pix_in.valid;
		if (arst_n && (!pix_in.valid || took)) begin
			nv = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (pend_q.size() != 0) begin
				s = pend_q.pop_front();
				pix_in.kind <= s.kind;
				pix_in.chan_a <= s.px.a;
				pix_in.chan_b <= s.px.b;
				pix_in.chan_c <= s.px.c;
				nv = 1'b1;
				if (--burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		pix_in.valid <= nv;
	end

	// Each input transfer advances the shadow filter.
	always @(posedge clk) begin
		pix_t p;
		took <= pix_in.valid && pix_in.ready;
		if (arst_n && pix_in.valid && pix_in.ready) begin
			p.a = pix_in.chan_a;
			p.b = pix_in.chan_b;
			p.c = pix_in.chan_c;
			predict_blur(pix_in.kind, p);
		end
	end

	// Receiver: a stall pattern that is picked anew at random, plus one long
	// hold-off once items pile up, so the result queue fills and the input is
	// backpressured.
	int unsigned rx_cycles = 0;
	int unsigned holdoff = 0;
	int unsigned rx_mode = 0;
	bit          held_once = 1'b0;
	always @(negedge clk) begin
		logic rdy;
		rx_cycles++;
		if (rx_cycles % 64 == 0)
			rx_mode = $urandom_range(0, 3);
		if (!held_once && arst_n && pend_q.size() >= 20) begin
			held_once = 1'b1;
			holdoff = 300;
		end
		if (holdoff > 0) begin
			holdoff--;
			rdy = 1'b0;
		end else
			case (rx_mode)
				0: rdy = 1'b1;
				1: rdy = ($urandom_range(0, 3) != 0);
				2: rdy = rx_cycles[0];
				default: rdy = ($urandom_range(0, 3) == 0);
			endcase
		pix_out.ready <= rdy;
	end

	// Monitor: check every output transfer against the oldest expected pixel.
	always @(posedge clk) begin
		blur_out_t e;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (blur_q.size() == 0)
				report("result with nothing expected");
			else begin
				e = blur_q.pop_front();
				if (pix_out.out_a !== e.px.a)
					report($sformatf("out_a %h, want %h", pix_out.out_a, e.px.a));
				if (pix_out.out_b !== e.px.b)
					report($sformatf("out_b %h, want %h", pix_out.out_b, e.px.b));
				if (pix_out.out_c !== e.px.c)
					report($sformatf("out_c %h, want %h", pix_out.out_c, e.px.c));
				if (pix_out.last_in_run !== e.last_in_run)
					report($sformatf("last_in_run %b, want %b",
						pix_out.last_in_run, e.last_in_run));
				if (pix_out.frame_done !== e.frame_done)
					report($sformatf("frame_done %b, want %b",
						pix_out.frame_done, e.frame_done));
			end
		end
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned random_items;
		n_errors = 0;
		took = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.kind = KIND_PIXEL;
		pix_in.chan_a = '0;
		pix_in.chan_b = '0;
		pix_in.chan_c = '0;
		pix_out.ready = 1'b0;
		sh_row = 0;
		sh_col = 0;
		sh_drain = 0;
		sh_width = FRAME_WIDTH_RST;
		sh_height = FRAME_HEIGHT_RST;
		for (int i = 0; i < 4 * MAX_WIDTH; i++)
			line_mem[i] = '0;
		for (int k = 0; k < 5; k++)
			for (int j = 0; j < 5; j++)
				win[k][j] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Smallest frame: all-zero, all-one and mixed samples, a stray flush
		// while taking pixels and a stray pixel while draining.
		write_reg(REG_FRAME_WIDTH, 5);
		write_reg(REG_FRAME_HEIGHT, 5);
		queue_item(KIND_FLUSH, '1);
		for (int i = 0; i < 25; i++)
			queue_item(KIND_PIXEL, (i % 3 == 0) ? '1 : ((i % 3 == 1) ? '0 : rand_pix()));
		queue_item(KIND_PIXEL, '1);
		for (int i = 0; i < 10; i++)
			queue_item(KIND_FLUSH, rand_pix());
		wait_idle();

		// Clamped-up corner cases: width and height registers below five.
		run_frame(0, 0, 20);

		random_items = 0;
		while (random_items < 260) begin
			int unsigned w, h;
			w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 14);
			h = $urandom_range(3, 9);
			random_items += (w < 5 ? 5 : w) * ((h < 5 ? 5 : h) + 2);
			run_frame(w, h, $urandom_range(0, 1) ? 15 : 0);
		end

		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
